/* rtl/kline_frame_receiver_macros.svh */
// Assertion macros for the K-line frame receiver.
// Every macro expects clk_i and rst_ni to exist in the including module.
`ifndef KLINE_FRAME_RECEIVER_MACROS_SVH
`define KLINE_FRAME_RECEIVER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define KFR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define KFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define KFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/kfr_pkg.sv */
// Package for the K-line frame receiver: field widths, codes and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kfr_pkg;

  localparam int MaxFrame    = 255;
  localparam int TickW       = 20;
  localparam int GapW        = 16;
  localparam int CfgIdxW     = 2;
  localparam int FifoDepth   = 4;
  localparam int FifoPtrW    = $clog2(FifoDepth);

  localparam logic [TickW-1:0] FirstByteTimeoutRst = TickW'(10000);
  localparam logic [GapW-1:0]  GapTimeoutRst       = GapW'(200);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFirstByteTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGapTimeout       = 2'd1;

  // Input commands.
  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdByte  = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;

  // Result kinds.
  localparam logic KindData = 1'b0;
  localparam logic KindDone = 1'b1;

  // Frame status codes.
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatTimeout  = 2'd1;
  localparam logic [1:0] StatSumError = 2'd2;
  localparam logic [1:0] StatOverflow = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] byte_count;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/kline_frame_receiver.sv */
// K-line (ISO 9141) response frame receiver with optional additive checksum.
// Depends on kfr_pkg and kline_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// The receiver takes one input word per clock cycle: a start word that opens a
// frame (expected length, zero for unknown, and whether a checksum byte closes
// it), received bytes, and 0.1 ms ticks that count waiting time. Every word is
// decoded combinationally against the frame state and produces zero, one or
// two result words, which go into a four-entry result queue. The output side
// drains that queue at one word per cycle while the consumer is ready. The
// input is ready whenever the queue has at least two free entries, so with a
// draining consumer a new input word is taken every cycle; only a stalled
// consumer holds the input. Configuration writes are always accepted and
// take effect on the next input word.
module kline_frame_receiver (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [kfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [kfr_pkg::TickW-1:0]    cfg_data_i,
  // Input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire logic [7:0]                   expected_len_i,
  input  wire logic                         check_sum_i,
  // Result channel.
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              kind_o,
  output logic [7:0]                        data_o,
  output logic [7:0]                        byte_count_o,
  output logic [1:0]                        status_o,
  output logic                              last_o
);

  `include "kline_frame_receiver_macros.svh"

  // Frame phases.
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhKData  = 3'd1;
  localparam logic [2:0] PhKSum   = 3'd2;
  localparam logic [2:0] PhUFirst = 3'd3;
  localparam logic [2:0] PhUGap   = 3'd4;

  localparam int CntW = kfr_pkg::FifoPtrW + 1;

  // Configuration registers.
  logic [kfr_pkg::TickW-1:0] first_tmo_q;
  logic [kfr_pkg::GapW-1:0]  gap_tmo_q;

  // Frame state.
  logic [2:0]                phase_q, phase_d;
  logic [kfr_pkg::TickW-1:0] wait_q, wait_d;
  logic [7:0]                received_q, received_d;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                prev_q, prev_d;
  logic [7:0]                target_q, target_d;
  logic                      sum_en_q, sum_en_d;

  // Result queue.
  kfr_pkg::res_t             fifo_q [kfr_pkg::FifoDepth];
  logic [kfr_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]           cnt_q;

  logic                      in_acc, out_acc, cfg_acc;
  logic [1:0]                n_res;
  kfr_pkg::res_t             res0, res1;
  logic [kfr_pkg::TickW-1:0] wait_inc;
  logic [7:0]                rec_inc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // Two free entries are needed since one word can yield two results.
  assign in_ready_o  = (cnt_q <= CntW'(kfr_pkg::FifoDepth - 2));
  assign in_acc      = in_valid_i && in_ready_o;

  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;

  assign kind_o       = fifo_q[rd_ptr_q].kind;
  assign data_o       = fifo_q[rd_ptr_q].data;
  assign byte_count_o = fifo_q[rd_ptr_q].byte_count;
  assign status_o     = fifo_q[rd_ptr_q].status;
  assign last_o       = fifo_q[rd_ptr_q].last;

  // The wait counter saturates instead of wrapping.
  assign wait_inc = (wait_q == '1) ? wait_q : wait_q + kfr_pkg::TickW'(1);
  assign rec_inc  = received_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    wait_d     = wait_q;
    received_d = received_q;
    sum_d      = sum_q;
    prev_d     = prev_q;
    target_d   = target_q;
    sum_en_d   = sum_en_q;
    n_res      = 2'd0;
    res0       = '{kind: kfr_pkg::KindData, data: rx_byte_i, byte_count: 8'd0,
                   status: kfr_pkg::StatOk, last: 1'b1};
    res1       = '{kind: kfr_pkg::KindDone, data: 8'd0, byte_count: rec_inc,
                   status: kfr_pkg::StatOk, last: 1'b1};

    unique case (cmd_i)
      kfr_pkg::CmdStart: begin
        target_d   = expected_len_i;
        sum_en_d   = check_sum_i;
        wait_d     = '0;
        received_d = '0;
        sum_d      = '0;
        prev_d     = '0;
        phase_d    = (expected_len_i != 8'd0) ? PhKData : PhUFirst;
      end

      kfr_pkg::CmdByte: begin
        if (phase_q == PhKSum) begin
          // Checksum byte of a known-length frame: compared, never passed on.
          n_res           = 2'd1;
          res0.kind       = kfr_pkg::KindDone;
          res0.data       = 8'd0;
          res0.byte_count = received_q;
          res0.status     = (rx_byte_i == sum_q) ? kfr_pkg::StatOk
                                                 : kfr_pkg::StatSumError;
          phase_d         = PhIdle;
          wait_d          = '0;
        end else if (phase_q != PhIdle) begin
          if (received_q >= 8'(kfr_pkg::MaxFrame)) begin
            n_res           = 2'd1;
            res0.kind       = kfr_pkg::KindDone;
            res0.data       = 8'd0;
            res0.byte_count = received_q;
            res0.status     = kfr_pkg::StatOverflow;
            phase_d         = PhIdle;
            wait_d          = '0;
          end else begin
            n_res      = 2'd1;
            received_d = rec_inc;
            wait_d     = '0;
            if (phase_q == PhKData) begin
              sum_d = sum_q + rx_byte_i;
              if (rec_inc == target_q) begin
                if (sum_en_q) begin
                  phase_d = PhKSum;
                end else begin
                  // Last data byte without checksum closes the frame at once.
                  n_res     = 2'd2;
                  res0.last = 1'b0;
                  phase_d   = PhIdle;
                end
              end
            end else begin
              // Unknown length: the newest byte stays out of the sum, since
              // it may turn out to be the checksum.
              if (received_q != 8'd0) begin
                sum_d = sum_q + prev_q;
              end
              prev_d  = rx_byte_i;
              phase_d = PhUGap;
            end
          end
        end
      end

      kfr_pkg::CmdTick: begin
        res0.kind = kfr_pkg::KindDone;
        res0.data = 8'd0;
        if (phase_q == PhKData || phase_q == PhUFirst) begin
          wait_d = wait_inc;
          if (wait_inc >= first_tmo_q) begin
            n_res           = 2'd1;
            res0.byte_count = 8'd0;
            res0.status     = kfr_pkg::StatTimeout;
            phase_d         = PhIdle;
            wait_d          = '0;
          end
        end else if (phase_q == PhKSum) begin
          wait_d = wait_inc;
          if (wait_inc >= first_tmo_q) begin
            n_res           = 2'd1;
            res0.byte_count = received_q;
            res0.status     = kfr_pkg::StatSumError;
            phase_d         = PhIdle;
            wait_d          = '0;
          end
        end else if (phase_q == PhUGap) begin
          wait_d = wait_inc;
          if (wait_inc >= {{(kfr_pkg::TickW - kfr_pkg::GapW){1'b0}}, gap_tmo_q}) begin
            n_res   = 2'd1;
            phase_d = PhIdle;
            wait_d  = '0;
            if (sum_en_q) begin
              res0.byte_count = received_q - 8'd1;
              res0.status     = (sum_q == prev_q) ? kfr_pkg::StatOk
                                                  : kfr_pkg::StatSumError;
            end else begin
              res0.byte_count = received_q;
              res0.status     = kfr_pkg::StatOk;
            end
          end
        end
      end

      default: begin
        // Unused command code: no effect.
      end
    endcase
  end

  // Control state, configuration and result queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_tmo_q <= kfr_pkg::FirstByteTimeoutRst;
      gap_tmo_q   <= kfr_pkg::GapTimeoutRst;
      phase_q     <= PhIdle;
      wait_q      <= '0;
      received_q  <= '0;
      sum_q       <= '0;
      prev_q      <= '0;
      target_q    <= '0;
      sum_en_q    <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_acc) begin
        if (cfg_index_i == kfr_pkg::RegFirstByteTimeout) begin
          first_tmo_q <= cfg_data_i;
        end else if (cfg_index_i == kfr_pkg::RegGapTimeout) begin
          gap_tmo_q <= cfg_data_i[kfr_pkg::GapW-1:0];
        end
      end
      if (in_acc) begin
        phase_q    <= phase_d;
        wait_q     <= wait_d;
        received_q <= received_d;
        sum_q      <= sum_d;
        prev_q     <= prev_d;
        target_q   <= target_d;
        sum_en_q   <= sum_en_d;
        wr_ptr_q   <= wr_ptr_q + kfr_pkg::FifoPtrW'(n_res);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + kfr_pkg::FifoPtrW'(1);
      end
      cnt_q <= cnt_q + (in_acc ? CntW'(n_res) : CntW'(0)) - (out_acc ? CntW'(1) : CntW'(0));
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      fifo_q[wr_ptr_q + kfr_pkg::FifoPtrW'(1)] <= res1;
    end
  end

  `KFR_ASSERT_ALWAYS(a_queue_bound, cnt_q <= CntW'(kfr_pkg::FifoDepth), "result queue overrun")
  `KFR_ASSERT_ALWAYS(a_frame_bound, received_q <= 8'(kfr_pkg::MaxFrame), "frame length over limit")
  `KFR_ASSERT_NEXT(a_start_opens, in_acc && cmd_i == kfr_pkg::CmdStart, phase_q != PhIdle, "start did not open a frame")
  `KFR_ASSERT_SAME(a_done_last, out_valid_o && kind_o == kfr_pkg::KindDone, last_o, "done result not marked last")

endmodule

`default_nettype wire

/* tb/kline_frame_receiver_tb.sv */
// Self-checking testbench for the K-line frame receiver.
// It predicts every result word from its own model of the frame state and compares them in order.
// Depends on kfr_pkg and the kline_frame_receiver RTL only.
`timescale 1ns / 1ps

module kline_frame_receiver_tb;
  import kfr_pkg::*;

  // The fourth command code has no meaning and must be ignored by the block.
  localparam logic [1:0] CmdUnused = 2'd3;

  // Cycles without any accepted word before the run is declared hung. The longest legal
  // quiet stretch is the long receiver hold-off plus the settle time between phases.
  localparam int IdleLimit    = 2000;
  // The block decodes each word combinationally, so this settle time covers any word still in flight.
  localparam int SettleCycles = 8;
  localparam int LongHold     = 150;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [7:0] expected_len;
    logic       check_sum;
  } kline_word_t;

  typedef enum logic [2:0] {
    FrIdle,
    FrLenData,
    FrLenSum,
    FrOpenFirst,
    FrOpenGap
  } frame_phase_e;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TickW-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  kline_word_t        held_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind_w;
  logic [7:0]         data_w;
  logic [7:0]         count_w;
  logic [1:0]         status_w;
  logic               last_w;

  kline_frame_receiver DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (held_word.cmd),
    .rx_byte_i      (held_word.rx_byte),
    .expected_len_i (held_word.expected_len),
    .check_sum_i    (held_word.check_sum),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind_w),
    .data_o         (data_w),
    .byte_count_o   (count_w),
    .status_o       (status_w),
    .last_o         (last_w)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor. It keeps its own copy of the frame state and of the two
  // timeout registers, and turns every accepted input word into the result
  // words that the block must produce for it.
  // ---------------------------------------------------------------------------
  frame_phase_e     frame_phase    = FrIdle;
  logic [TickW-1:0] tick_count     = '0;
  logic [7:0]       byte_total     = '0;
  logic [7:0]       sum_acc        = '0;
  logic [7:0]       prev_byte      = '0;
  logic [7:0]       len_goal       = '0;
  logic             sum_on         = 1'b0;
  logic [TickW-1:0] cfg_first_wait = FirstByteTimeoutRst;
  logic [GapW-1:0]  cfg_gap_wait   = GapTimeoutRst;

  res_t        step_results[$];
  res_t        expected_results[$];
  kline_word_t pending_words[$];
  int          words_queued = 0;
  int          fail_count   = 0;

  function automatic res_t make_result(input logic k, input logic [7:0] d,
                                       input logic [7:0] n, input logic [1:0] s,
                                       input logic l);
    res_t r;
    r.kind       = k;
    r.data       = d;
    r.byte_count = n;
    r.status     = s;
    r.last       = l;
    return r;
  endfunction

  // The wait counter saturates at its width; a timeout fires once it reaches the limit,
  // so a limit of zero fires on the very first tick.
  function automatic logic wait_expired(input logic [TickW-1:0] limit);
    if (tick_count != '1) tick_count = tick_count + 1'b1;
    return tick_count >= limit;
  endfunction

  task automatic close_frame(input logic [7:0] count, input logic [1:0] code);
    frame_phase = FrIdle;
    tick_count  = '0;
    step_results.push_back(make_result(KindDone, 8'd0, count, code, 1'b0));
  endtask

  task automatic apply_word(input kline_word_t w);
    res_t r;
    step_results.delete();
    case (w.cmd)
      CmdStart: begin
        // A start always opens a new frame; a frame in progress is dropped silently.
        len_goal    = w.expected_len;
        sum_on      = w.check_sum;
        tick_count  = '0;
        byte_total  = '0;
        sum_acc     = '0;
        prev_byte   = '0;
        frame_phase = (w.expected_len != 8'd0) ? FrLenData : FrOpenFirst;
      end
      CmdByte: begin
        if (frame_phase == FrLenSum) begin
          // The checksum byte of a known-length frame is consumed, not passed on.
          close_frame(byte_total, (w.rx_byte == sum_acc) ? StatOk : StatSumError);
        end else if (frame_phase != FrIdle) begin
          if (byte_total >= MaxFrame) begin
            close_frame(byte_total, StatOverflow);
          end else begin
            step_results.push_back(make_result(KindData, w.rx_byte, 8'd0, StatOk, 1'b0));
            byte_total = byte_total + 8'd1;
            tick_count = '0;
            if (frame_phase == FrLenData) begin
              sum_acc = sum_acc + w.rx_byte;
              if (byte_total == len_goal) begin
                if (sum_on) frame_phase = FrLenSum;
                else close_frame(byte_total, StatOk);
              end
            end else begin
              // Open-length frames sum every byte but the newest, which may be the checksum.
              if (byte_total > 8'd1) sum_acc = sum_acc + prev_byte;
              prev_byte   = w.rx_byte;
              frame_phase = FrOpenGap;
            end
          end
        end
      end
      CmdTick: begin
        case (frame_phase)
          FrLenData, FrOpenFirst: begin
            if (wait_expired(cfg_first_wait)) close_frame(8'd0, StatTimeout);
          end
          FrLenSum: begin
            if (wait_expired(cfg_first_wait)) close_frame(byte_total, StatSumError);
          end
          FrOpenGap: begin
            if (wait_expired(TickW'(cfg_gap_wait))) begin
              if (sum_on) close_frame(byte_total - 8'd1,
                                      (sum_acc == prev_byte) ? StatOk : StatSumError);
              else close_frame(byte_total, StatOk);
            end
          end
          default: ;
        endcase
      end
      CmdUnused: ;
      default: ;
    endcase
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. It offers the queued words one at a time, holds each one
  // steady until it is taken, and waits a random number of cycles after each.
  // Now and then it switches into a stretch of back-to-back words.
  // ---------------------------------------------------------------------------
  int tx_gap   = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_word(held_word);
      if (in_valid && !in_ready) begin
        // The word is still waiting; leave it untouched.
      end else if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        held_word <= pending_words.pop_front();
        in_valid  <= 1'b1;
        if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Each result word taken is checked against the oldest
  // expectation. The ready line stalls at random after each word, and once,
  // while a long run of input is still queued, it holds off for a long
  // stretch so that the result queue fills and the block stops taking input.
  // ---------------------------------------------------------------------------
  int   rx_stall  = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   rx_burst  = 1'b0;
  res_t seen_word;
  res_t want_word;

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_word = make_result(kind_w, data_w, count_w, status_w, last_w);
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d data %0d count %0d status %0d",
                 kind_w, data_w, count_w, status_w);
          fail_count++;
        end else begin
          want_word = expected_results.pop_front();
          check_field("kind", want_word.kind, seen_word.kind);
          check_field("data", want_word.data, seen_word.data);
          check_field("byte_count", want_word.byte_count, seen_word.byte_count);
          check_field("status", want_word.status, seen_word.status);
          check_field("last", want_word.last, seen_word.last);
        end
        if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 6);
      end
      if (!hold_done && pending_words.size() > 100) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall = rx_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hang detector: any accepted word on any channel restarts the count.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Fields that the command does not use get random values so that every bit toggles.
  task automatic push_word(input logic [1:0] cmd, input logic [7:0] value,
                           input logic [7:0] len, input logic flag);
    kline_word_t w;
    w.cmd          = cmd;
    w.rx_byte      = (cmd == CmdByte) ? value : 8'($urandom);
    w.expected_len = (cmd == CmdStart) ? len : 8'($urandom);
    w.check_sum    = (cmd == CmdStart) ? flag : 1'($urandom);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_word(CmdTick, 8'd0, 8'd0, 1'b0);
  endtask

  // One random frame: mostly well-formed known- or open-length frames with random
  // content and short waits, some ending in a timeout, and a little noise.
  // Timeouts are only driven to expiry when the current register values are small.
  task automatic queue_random_frame();
    int         style;
    int         len;
    int         n_bytes;
    int         spare;
    int         gspare;
    logic       flag;
    logic       cut_short;
    logic [7:0] acc;
    logic [7:0] b;
    style  = $urandom_range(0, 9);
    flag   = 1'($urandom);
    acc    = '0;
    spare  = (cfg_first_wait > 4) ? 3 : ((cfg_first_wait > 1) ? int'(cfg_first_wait) - 1 : 0);
    gspare = (cfg_gap_wait > 4) ? 3 : ((cfg_gap_wait > 1) ? int'(cfg_gap_wait) - 1 : 0);
    if (style < 6) begin
      len       = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 120) : $urandom_range(1, 6);
      n_bytes   = len;
      cut_short = 1'b0;
      if (cfg_first_wait <= 20 && $urandom_range(0, 9) == 0) begin
        cut_short = 1'b1;
        n_bytes   = $urandom_range(0, len);
      end
      push_word(CmdStart, 8'd0, 8'(len), flag);
      for (int i = 0; i < n_bytes; i++) begin
        push_ticks($urandom_range(0, spare));
        b   = 8'($urandom);
        acc = acc + b;
        push_word(CmdByte, b, 8'd0, 1'b0);
      end
      if (cut_short) push_ticks((cfg_first_wait == 0) ? 1 : int'(cfg_first_wait));
      else if (flag) push_word(CmdByte, ($urandom_range(0, 2) != 0) ? acc : 8'($urandom),
                               8'd0, 1'b0);
    end else if (style < 9) begin
      n_bytes = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
      push_word(CmdStart, 8'd0, 8'd0, flag);
      for (int i = 0; i < n_bytes; i++) begin
        push_ticks($urandom_range(0, (i == 0) ? spare : gspare));
        // The last byte of an open-length frame is usually the right checksum.
        b   = (i == n_bytes - 1 && flag && $urandom_range(0, 2) != 0) ? acc : 8'($urandom);
        acc = acc + b;
        push_word(CmdByte, b, 8'd0, 1'b0);
      end
      // With large timeouts the frame stays open and the next start drops it.
      if (n_bytes == 0) begin
        if (cfg_first_wait <= 20) push_ticks((cfg_first_wait == 0) ? 1 : int'(cfg_first_wait));
      end else if (cfg_gap_wait <= 20) begin
        push_ticks((cfg_gap_wait == 0) ? 1 : int'(cfg_gap_wait));
      end
    end else begin
      repeat ($urandom_range(1, 3))
        push_word(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic queue_random_run(input int count);
    int first;
    first = words_queued;
    while (words_queued - first < count) queue_random_frame();
  endtask

  // Lets the queue run dry, which also makes the sender pause until every
  // expected result word has come back.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [TickW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == RegFirstByteTimeout) cfg_first_wait = value;
    else cfg_gap_wait = value[GapW-1:0];
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence. Registers are only written with the block idle, between
  // phases. Each phase runs under a different pair of timeout values.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timeout values. Words outside a frame and the unused command are ignored.
    push_word(CmdByte, 8'hFF, 8'd0, 1'b0);
    push_word(CmdTick, 8'd0, 8'd0, 1'b0);
    push_word(CmdUnused, 8'hA5, 8'hFF, 1'b1);
    // A one-byte frame without checksum gives a data word and a done word for one input.
    push_word(CmdStart, 8'd0, 8'd1, 1'b0);
    push_word(CmdByte, 8'h00, 8'd0, 1'b0);
    // Known-length checksum that matches, then one that does not.
    push_word(CmdStart, 8'd0, 8'd2, 1'b1);
    push_word(CmdByte, 8'hFF, 8'd0, 1'b0);
    push_word(CmdByte, 8'h01, 8'd0, 1'b0);
    push_word(CmdByte, 8'h00, 8'd0, 1'b0);
    push_word(CmdStart, 8'd0, 8'd1, 1'b1);
    push_word(CmdByte, 8'h80, 8'd0, 1'b0);
    push_word(CmdByte, 8'h7F, 8'd0, 1'b0);
    // A start in the middle of a frame drops it; the open-length frame then ends on its gap.
    push_word(CmdStart, 8'd0, 8'd3, 1'b0);
    push_word(CmdByte, 8'h55, 8'd0, 1'b0);
    push_word(CmdStart, 8'd0, 8'd0, 1'b1);
    push_word(CmdByte, 8'h12, 8'd0, 1'b0);
    push_word(CmdByte, 8'h34, 8'd0, 1'b0);
    push_word(CmdByte, 8'h46, 8'd0, 1'b0);
    push_ticks(200);
    drain();

    // Short timeouts: every kind of timeout, then overflow and the longest known frame.
    write_reg(RegFirstByteTimeout, TickW'(3));
    write_reg(RegGapTimeout, TickW'(2));
    push_word(CmdStart, 8'd0, 8'd4, 1'b0);
    push_word(CmdByte, 8'h3C, 8'd0, 1'b0);
    push_ticks(3);
    push_word(CmdStart, 8'd0, 8'd1, 1'b1);
    push_word(CmdByte, 8'h3C, 8'd0, 1'b0);
    push_ticks(3);
    push_word(CmdStart, 8'd0, 8'd0, 1'b1);
    push_ticks(3);
    push_word(CmdStart, 8'd0, 8'd0, 1'b0);
    push_word(CmdByte, 8'h01, 8'd0, 1'b0);
    push_word(CmdByte, 8'h02, 8'd0, 1'b0);
    push_ticks(2);
    push_word(CmdStart, 8'd0, 8'd0, 1'b1);
    push_word(CmdByte, 8'h01, 8'd0, 1'b0);
    push_word(CmdByte, 8'h02, 8'd0, 1'b0);
    push_word(CmdByte, 8'h04, 8'd0, 1'b0);
    push_ticks(2);
    push_word(CmdStart, 8'd0, 8'd0, 1'($urandom));
    repeat (MaxFrame + 1) push_word(CmdByte, 8'($urandom), 8'd0, 1'b0);
    push_word(CmdStart, 8'd0, 8'd255, 1'b0);
    repeat (MaxFrame) push_word(CmdByte, 8'($urandom), 8'd0, 1'b0);
    drain();

    // Zero timeouts fire on the first tick in every waiting phase.
    write_reg(RegFirstByteTimeout, TickW'(0));
    write_reg(RegGapTimeout, TickW'(0));
    push_word(CmdStart, 8'd0, 8'd2, 1'b0);
    push_ticks(1);
    push_word(CmdStart, 8'd0, 8'd0, 1'b0);
    push_ticks(1);
    push_word(CmdStart, 8'd0, 8'd0, 1'b1);
    push_word(CmdByte, 8'h00, 8'd0, 1'b0);
    push_ticks(1);
    push_word(CmdStart, 8'd0, 8'd1, 1'b1);
    push_word(CmdByte, 8'h9A, 8'd0, 1'b0);
    push_ticks(1);
    queue_random_run(20);
    drain();

    // Timeouts of one tick each.
    write_reg(RegFirstByteTimeout, TickW'(1));
    write_reg(RegGapTimeout, TickW'(1));
    queue_random_run(20);
    drain();

    // Highest timeouts: frames end on bytes, overflow or a new start only.
    write_reg(RegFirstByteTimeout, TickW'(20'hFFFFF));
    write_reg(RegGapTimeout, TickW'(16'hFFFF));
    queue_random_run(20);
    drain();

    // Two runs with moderate random timeouts carry most of the random traffic.
    repeat (2) begin
      write_reg(RegFirstByteTimeout, TickW'($urandom_range(2, 12)));
      write_reg(RegGapTimeout, TickW'($urandom_range(1, 8)));
      queue_random_run(40);
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
